// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Generic clocked property, off while reset is low.
`define MVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define MVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define MVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the matrix-vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int NUM_COMP      = 4;
    localparam int IDX_IN_W      = 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_DEF       = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_XFORM = 2'd2
    } mvt_cmd_t;

    // pipeline stage load enables
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } mvt_ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } mvt_result_t;

endpackage

// ----- hw/rtl/matrix4_vector_transform_unit.sv -----
// ----------------------------------------------------------------------------
// matrix4_vector_transform_unit
// Read and transform words pass product, pair-sum, total and output registers.
// Throughput: one word per cycle unless m_ready stalls it; each lane's product
// stage has one 32x32 multiplier per matrix column, so a full transform enters
// every cycle. Writes give no result and update the matrix at their accept edge.
// Reset (aresetn low, synchronous): matrix cleared to zero, pipeline emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix4_vector_transform_unit
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DIM       = DIM_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // command word
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [IDX_IN_W-1:0]        s_row_index,
    input  logic [IDX_IN_W-1:0]        s_col_index,
    input  logic signed [DATA_W-1:0]   s_elem_value,
    input  logic signed [DATA_W-1:0]   s_vec_x,
    input  logic signed [DATA_W-1:0]   s_vec_y,
    input  logic signed [DATA_W-1:0]   s_vec_z,
    input  logic signed [DATA_W-1:0]   s_vec_w,
    // result word
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DATA_W-1:0]   m_read_data,
    output logic signed [DATA_W-1:0]   m_out_x,
    output logic signed [DATA_W-1:0]   m_out_y,
    output logic signed [DATA_W-1:0]   m_out_z,
    output logic signed [DATA_W-1:0]   m_out_w,
    output logic                       m_saturated
);

    localparam int IDX_W = $clog2(DIM);
    localparam int SUM_W = PROD_W + $clog2(DIM);

    // ------------------------------------------------------------------
    // Matrix store: DIM x DIM registers, each lane reads its row at a
    // fixed place; the read command reads one element at the indexed spot.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] matrix_reg [DIM][DIM];

    logic                     idx_ok;
    logic [IDX_W-1:0]         row_sel;
    logic [IDX_W-1:0]         col_sel;
    logic signed [DATA_W-1:0] vec_all [NUM_COMP];
    logic signed [DATA_W-1:0] vec_in  [DIM];
    logic signed [DATA_W-1:0] rd_value;

    // pipeline control
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic m_valid_reg, m_valid_next;
    logic xf1_reg, xf2_reg, xf3_reg;
    logic signed [DATA_W-1:0] rd1_reg, rd2_reg, rd3_reg;

    logic     rdy1, rdy2, rdy3;
    logic     accept;
    logic     has_result;
    logic     en_out;
    logic     wr_en;
    mvt_ctl_t ctl;

    logic signed [SUM_W-1:0] lane_total [DIM];
    mvt_result_t             merged;
    mvt_result_t             out_reg;

    assign idx_ok  = ({1'b0, s_row_index} < 3'(DIM)) && ({1'b0, s_col_index} < 3'(DIM));
    assign row_sel = s_row_index[IDX_W-1:0];
    assign col_sel = s_col_index[IDX_W-1:0];

    assign vec_all[0] = s_vec_x;
    assign vec_all[1] = s_vec_y;
    assign vec_all[2] = s_vec_z;
    assign vec_all[3] = s_vec_w;

    for (genvar i = 0; i < DIM; i++) begin : g_vec
        assign vec_in[i] = vec_all[i];
    end

    assign rd_value = idx_ok ? matrix_reg[row_sel][col_sel] : '0;

    // ------------------------------------------------------------------
    // Handshake: each stage frees itself when empty or when its word moves
    // on, so a waiting result at m_ does not block the input while bubbles
    // remain in the pipe.
    // ------------------------------------------------------------------
    assign rdy3    = !v3_reg || !m_valid_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && s_ready;
    assign en_out  = v3_reg && rdy3;

    assign ctl.en1 = accept;
    assign ctl.en2 = v1_reg && rdy2;
    assign ctl.en3 = v2_reg && rdy3;

    always_comb begin
        has_result = 1'b0;
        wr_en      = 1'b0;
        case (s_cmd)
            CMD_WRITE: wr_en      = accept && idx_ok;
            CMD_READ:  has_result = 1'b1;
            CMD_XFORM: has_result = 1'b1;
            default:   has_result = 1'b0;
        endcase
    end

    always_comb begin
        v1_next = v1_reg;
        if (accept) begin
            v1_next = has_result;
        end else if (ctl.en2) begin
            v1_next = 1'b0;
        end

        v2_next = v2_reg;
        if (ctl.en2) begin
            v2_next = 1'b1;
        end else if (ctl.en3) begin
            v2_next = 1'b0;
        end

        v3_next = v3_reg;
        if (ctl.en3) begin
            v3_next = 1'b1;
        end else if (en_out) begin
            v3_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (en_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // matrix store, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    matrix_reg[r][c] <= '0;
                end
            end
        end else if (wr_en) begin
            matrix_reg[row_sel][col_sel] <= s_elem_value;
        end
    end

    // command flag and read data ride alongside the lane pipeline
    always_ff @(posedge aclk) begin
        if (ctl.en1) begin
            xf1_reg <= (s_cmd == CMD_XFORM);
            rd1_reg <= rd_value;
        end
        if (ctl.en2) begin
            xf2_reg <= xf1_reg;
            rd2_reg <= rd1_reg;
        end
        if (ctl.en3) begin
            xf3_reg <= xf2_reg;
            rd3_reg <= rd2_reg;
        end
        if (en_out) begin
            out_reg <= merged;
        end
    end

    // ------------------------------------------------------------------
    // Row lanes, one per matrix row
    // ------------------------------------------------------------------
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        mvt_lane #(
            .DIM       (DIM),
            .FRAC_BITS (FRAC_BITS),
            .SUM_W     (SUM_W)
        ) u_lane (
            .aclk      (aclk),
            .ctl       (ctl),
            .row_elems (matrix_reg[r]),
            .vec       (vec_in),
            .total     (lane_total[r])
        );
    end

    mvt_merge #(
        .DIM   (DIM),
        .SUM_W (SUM_W)
    ) u_merge (
        .lane_total (lane_total),
        .is_xform   (xf3_reg),
        .rd_data    (rd3_reg),
        .result     (merged)
    );

    // output register drives the result word
    assign m_valid     = m_valid_reg;
    assign m_read_data = out_reg.read_data;
    assign m_out_x     = out_reg.out_x;
    assign m_out_y     = out_reg.out_y;
    assign m_out_z     = out_reg.out_z;
    assign m_out_w     = out_reg.out_w;
    assign m_saturated = out_reg.saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MVT_ASSERT(a_write_no_result, aclk, aresetn, (accept && s_cmd == CMD_WRITE) |=> !v1_reg, "write entered pipeline")
    `MVT_ASSERT(a_read_enters, aclk, aresetn, (accept && s_cmd == CMD_READ) |=> (v1_reg && !xf1_reg), "read lost at entry")
    `MVT_ASSERT_IMPL(a_stall_means_full, aclk, aresetn, !s_ready, v1_reg && v2_reg && v3_reg && m_valid_reg, "input stalled with room in pipe")
    `MVT_ASSERT_IMPL(a_sat_only_xform, aclk, aresetn, m_valid_reg && m_saturated, m_read_data == '0, "saturation flag on read word")

endmodule

// ----- hw/rtl/mvt_lane.sv -----
// ----------------------------------------------------------------------------
// mvt_lane
// One row lane: products, pair sums, total sum shifted by FRAC_BITS.
// ----------------------------------------------------------------------------
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int DIM       = DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_W     = PROD_W + $clog2(DIM)
) (
    input  logic                     aclk,
    input  mvt_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] row_elems [DIM],
    input  logic signed [DATA_W-1:0] vec       [DIM],
    output logic signed [SUM_W-1:0]  total
);

    localparam int NP     = (DIM + 1) / 2;
    localparam int PAIR_W = PROD_W + 1;

    logic signed [PROD_W-1:0] prod_reg  [DIM];
    logic signed [PAIR_W-1:0] pair_next [NP];
    logic signed [PAIR_W-1:0] pair_reg  [NP];
    logic signed [SUM_W-1:0]  total_next;
    logic signed [SUM_W-1:0]  total_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en1) begin
            for (int i = 0; i < DIM; i++) begin
                prod_reg[i] <= PROD_W'(row_elems[i]) * PROD_W'(vec[i]);
            end
        end
    end

    for (genvar k = 0; k < NP; k++) begin : g_pair
        if (2 * k + 1 < DIM) begin : g_two
            assign pair_next[k] = PAIR_W'(prod_reg[2*k]) + PAIR_W'(prod_reg[2*k+1]);
        end else begin : g_one
            assign pair_next[k] = PAIR_W'(prod_reg[2*k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en2) begin
            for (int k = 0; k < NP; k++) begin
                pair_reg[k] <= pair_next[k];
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < NP; k++) begin
            acc = acc + SUM_W'(pair_reg[k]);
        end
        total_next = acc >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en3) begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

// ----- hw/rtl/mvt_merge.sv -----
// ----------------------------------------------------------------------------
// mvt_merge
// Saturates the lane totals, ORs the clamp flags, forms the result word.
// ----------------------------------------------------------------------------
module mvt_merge
    import mvt_pkg::*;
#(
    parameter int DIM   = DIM_DEF,
    parameter int SUM_W = PROD_W + $clog2(DIM)
) (
    input  logic signed [SUM_W-1:0]  lane_total [DIM],
    input  logic                     is_xform,
    input  logic signed [DATA_W-1:0] rd_data,
    output mvt_result_t              result
);

    localparam int HI_W = SUM_W - DATA_W + 1;

    logic signed [DATA_W-1:0] comp [NUM_COMP];
    logic                     sat;

    always_comb begin
        logic [HI_W-1:0] hi;
        for (int r = 0; r < NUM_COMP; r++) begin
            comp[r] = '0;
        end
        sat = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            hi = lane_total[r][SUM_W-1:DATA_W-1];
            if (hi == '0 || hi == '1) begin
                comp[r] = lane_total[r][DATA_W-1:0];
            end else begin
                sat = 1'b1;
                comp[r] = lane_total[r][SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        result = '0;
        if (is_xform) begin
            result.out_x     = comp[0];
            result.out_y     = comp[1];
            result.out_z     = comp[2];
            result.out_w     = comp[3];
            result.saturated = sat;
        end else begin
            result.read_data = rd_data;
        end
    end

endmodule
